### sv/tcphs_pkg.sv
// ----------------------------------------------------------------------------
// tcphs_pkg
// shared types, codes and constants of the tcp server handshake tracker
// ----------------------------------------------------------------------------
package tcphs_pkg;

    // tcp flag bits
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_PSH = 8'h08;
    localparam logic [7:0] FLAG_ACK = 8'h10;

    localparam logic [15:0] HDR_BYTES = 16'd20;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PORT   = 2'd1;
    localparam logic [1:0] ST_NOCONN = 2'd2;
    localparam logic [1:0] ST_LONG   = 2'd3;

    // reported connection state codes
    localparam logic [1:0] CS_CLOSED  = 2'd0;
    localparam logic [1:0] CS_SYNRCVD = 2'd1;
    localparam logic [1:0] CS_ESTAB   = 2'd2;

    // item kinds
    localparam logic KIND_SEGMENT  = 1'b0;
    localparam logic KIND_TRANSMIT = 1'b1;

    // register indexes (paddr[3:2])
    localparam int unsigned ADDR_W = 4;
    localparam logic [1:0] REG_LOCAL_PORT = 2'd0;
    localparam logic [1:0] REG_INIT_SEQ   = 2'd1;
    localparam logic [1:0] REG_MAX_RX     = 2'd2;
    localparam logic [1:0] REG_MAX_TX     = 2'd3;

    // register reset values
    localparam logic [15:0] RST_LOCAL_PORT = 16'd15118;
    localparam logic [31:0] RST_INIT_SEQ   = 32'h0102_0304;
    localparam logic [15:0] RST_MAX_RX     = 16'd1000;
    localparam logic [15:0] RST_MAX_TX     = 16'd200;

    // stream word widths
    localparam int unsigned IN_DATA_W  = 136;
    localparam int unsigned OUT_DATA_W = 128;
    localparam int unsigned OUT_USER_W = 2;

    typedef enum logic [2:0] {
        PH_CLOSED  = 3'b001,
        PH_SYNRCVD = 3'b010,
        PH_ESTAB   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [15:0] local_port;
        logic [31:0] initial_seq;
        logic [15:0] max_rx_payload;
        logic [15:0] max_tx_packet;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [15:0] ip_payload_len;
        logic [3:0]  data_offset;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dst_port;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [7:0]  seg_flags;
        logic [7:0]  tx_payload_len;
    } t_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_flags;
        logic [31:0] tx_seq;
        logic [31:0] tx_ack;
        logic [15:0] tx_dst_port;
        logic [15:0] tx_length;
        logic        deliver_valid;
        logic [15:0] deliver_len;
        logic [1:0]  conn_state;
        logic [1:0]  status;
    } t_result;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_CLOSED:  code = CS_CLOSED;
            PH_SYNRCVD: code = CS_SYNRCVD;
            PH_ESTAB:   code = CS_ESTAB;
            default:    code = CS_CLOSED;
        endcase
        return code;
    endfunction

endpackage

### sv/tcphs_regs.sv
// ----------------------------------------------------------------------------
// tcphs_regs
// apb configuration registers of the handshake tracker
// ----------------------------------------------------------------------------
module tcphs_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [tcphs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output tcphs_pkg::t_cfg        o_cfg
);
    import tcphs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_port     <= RST_LOCAL_PORT;
            r_cfg.initial_seq    <= RST_INIT_SEQ;
            r_cfg.max_rx_payload <= RST_MAX_RX;
            r_cfg.max_tx_packet  <= RST_MAX_TX;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOCAL_PORT: r_cfg.local_port     <= pwdata[15:0];
                REG_INIT_SEQ:   r_cfg.initial_seq    <= pwdata;
                REG_MAX_RX:     r_cfg.max_rx_payload <= pwdata[15:0];
                REG_MAX_TX:     r_cfg.max_tx_packet  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOCAL_PORT: prdata = {16'd0, r_cfg.local_port};
            REG_INIT_SEQ:   prdata = r_cfg.initial_seq;
            REG_MAX_RX:     prdata = {16'd0, r_cfg.max_rx_payload};
            REG_MAX_TX:     prdata = {16'd0, r_cfg.max_tx_packet};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/tcphs_engine.sv
// ----------------------------------------------------------------------------
// tcphs_engine
// connection state registers and the per-word decision logic
// ----------------------------------------------------------------------------
module tcphs_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  tcphs_pkg::t_cfg    i_cfg,
    input  tcphs_pkg::t_item   i_item,
    output tcphs_pkg::t_result o_result
);
    import tcphs_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [15:0] r_peer, n_peer;

    logic [5:0]  hdr_len;
    logic [15:0] pay;
    logic [15:0] tx_len;
    t_result     res;

    assign hdr_len = {i_item.data_offset, 2'b00};
    assign pay     = (i_item.ip_payload_len >= {10'd0, hdr_len}) ?
                     i_item.ip_payload_len - {10'd0, hdr_len} : 16'd0;
    assign tx_len  = {8'd0, i_item.tx_payload_len} + HDR_BYTES;

    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        n_ack   = r_ack;
        n_peer  = r_peer;
        res     = '0;
        res.status = ST_OK;

        if (i_item.kind == KIND_SEGMENT) begin
            if (i_item.seg_dst_port != i_cfg.local_port) begin
                res.status = ST_PORT;
            end else if (i_item.seg_flags == FLAG_SYN) begin
                // syn while closed opens the connection, otherwise dropped
                if (r_phase == PH_CLOSED) begin
                    n_peer         = i_item.seg_src_port;
                    n_seq          = i_cfg.initial_seq;
                    n_ack          = i_item.seg_seq + 32'd1;
                    n_phase        = PH_SYNRCVD;
                    res.tx_valid   = 1'b1;
                    res.tx_flags   = FLAG_SYN | FLAG_ACK;
                    res.tx_length  = HDR_BYTES;
                end
            end else if (i_item.seg_flags == FLAG_ACK && r_phase == PH_SYNRCVD) begin
                if (i_item.seg_ack == r_seq + 32'd1) begin
                    n_phase = PH_ESTAB;
                end
            end else if (r_phase != PH_ESTAB) begin
                res.status = ST_NOCONN;
            end else if (pay != 16'd0 && pay < i_cfg.max_rx_payload) begin
                n_ack             = i_item.seg_seq + {16'd0, pay};
                n_seq             = i_item.seg_ack;
                res.deliver_valid = 1'b1;
                res.deliver_len   = pay;
                res.tx_valid      = 1'b1;
                res.tx_flags      = FLAG_ACK;
                res.tx_length     = HDR_BYTES;
            end else begin
                if ((i_item.seg_flags & FLAG_ACK) != 8'd0) begin
                    n_seq = i_item.seg_ack;
                end
                res.status = (pay != 16'd0) ? ST_LONG : ST_OK;
            end
        end else begin
            if (r_phase != PH_ESTAB) begin
                res.status = ST_NOCONN;
            end else if (tx_len >= i_cfg.max_tx_packet) begin
                res.status = ST_LONG;
            end else begin
                res.tx_valid  = 1'b1;
                res.tx_flags  = FLAG_PSH | FLAG_ACK;
                res.tx_length = tx_len;
            end
        end

        // header carries the state as left by this word
        if (res.tx_valid) begin
            res.tx_seq      = n_seq;
            res.tx_ack      = n_ack;
            res.tx_dst_port = n_peer;
        end
        res.conn_state = phase_code(n_phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CLOSED;
            r_seq   <= 32'd0;
            r_ack   <= 32'd0;
            r_peer  <= 16'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_ack   <= n_ack;
            r_peer  <= n_peer;
        end
    end

    assign o_result = res;

endmodule

### sv/tcp_server_handshake_tracker_top.sv
// ----------------------------------------------------------------------------
// tcp_server_handshake_tracker_top
// minimal server-side tcp connection tracker with stream ports and apb config
// ----------------------------------------------------------------------------
// Takes one word per cycle while results are taken: either a parsed received
// segment (tuser 0) or a request to send a payload (tuser 1), and returns
// exactly one result word for each, in order. A word is held in the input
// register, decided by the engine against the connection state (closed, syn
// received, established) and moved into the output register, which offers
// the result on the master side. Sustained rate is one word per clock while
// results are taken; it is set by the single state update in the engine,
// which finishes within the cycle a word leaves the input register. The input
// register takes a new word in the same cycle its word moves on and holds it
// while the output register is full and not taken; back-pressure from the
// master side reaches o_s_tready in the same cycle. The user must write the
// registers over apb only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module tcp_server_handshake_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream: received segments and transmit requests
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata from bit 0: ip_payload_len(16) data_offset(4) seg_src_port(16)
    // seg_dst_port(16) seg_seq(32) seg_ack(32) seg_flags(8) tx_payload_len(8),
    // zero fill
    input  logic [tcphs_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // tuser: kind(1)
    input  logic                               i_s_tuser,
    // master stream: results
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata from bit 0: tx_flags(8) tx_seq(32) tx_ack(32) tx_dst_port(16)
    // tx_length(16) deliver_len(16) conn_state(2) status(2), zero fill
    output logic [tcphs_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // tuser from bit 0: tx_valid(1) deliver_valid(1)
    output logic [tcphs_pkg::OUT_USER_W-1:0]   o_m_tuser,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tcphs_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tcphs_pkg::*;

    t_cfg    cfg;
    t_item   item;
    t_result result;

    // input register
    logic                 r_in_valid;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                 r_in_kind;

    // output register
    logic    r_out_valid;
    t_result r_out;

    logic advance;   // word in input register moves to the output register
    logic s_take;

    assign advance    = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | advance;
    assign s_take     = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_data <= i_s_tdata;
            r_in_kind <= i_s_tuser;
        end
    end

    // unpack the input word
    assign item.kind           = r_in_kind;
    assign item.ip_payload_len = r_in_data[15:0];
    assign item.data_offset    = r_in_data[19:16];
    assign item.seg_src_port   = r_in_data[35:20];
    assign item.seg_dst_port   = r_in_data[51:36];
    assign item.seg_seq        = r_in_data[83:52];
    assign item.seg_ack        = r_in_data[115:84];
    assign item.seg_flags      = r_in_data[123:116];
    assign item.tx_payload_len = r_in_data[131:124];

    tcphs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // state only moves when the word is committed to the output register
    tcphs_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_item   (item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    // pack the result word
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0,
                         r_out.status,
                         r_out.conn_state,
                         r_out.deliver_len,
                         r_out.tx_length,
                         r_out.tx_dst_port,
                         r_out.tx_ack,
                         r_out.tx_seq,
                         r_out.tx_flags};
    assign o_m_tuser  = {r_out.deliver_valid, r_out.tx_valid};

    // a header is only ever sent with a connection at least half open
    a_tx_needs_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_valid) |-> (r_out.conn_state != CS_CLOSED))
        else $error("header sent while closed");

    // delivered data is always acknowledged with status ok
    a_deliver_acked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.deliver_valid) |->
        (r_out.tx_valid && r_out.tx_flags == FLAG_ACK && r_out.status == ST_OK))
        else $error("delivery without ack");

    // a refused word produces nothing
    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
        (!r_out.tx_valid && !r_out.deliver_valid))
        else $error("output on refused word");

    // the input register never drops a word: a held word stays held
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data)))
        else $error("input word lost");

endmodule

### dv/tb_tcp_server_handshake_tracker_top.sv
// ----------------------------------------------------------------------------
// tb_tcp_server_handshake_tracker_top
// self-checking bench for the tcp server handshake tracker
// ----------------------------------------------------------------------------
// Walks the connection from closed through syn received to established with
// directed words, then runs randomized segment and transmit traffic under
// several register settings. Each accepted word is run through a local model
// of the connection state, and every result word is compared field by field
// with the oldest prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_tcp_server_handshake_tracker_top;
    import tcphs_pkg::*;

    class conn_scoreboard;
        t_cfg        regs;
        t_phase      phase;
        logic [31:0] snd_seq;
        logic [31:0] rcv_ack;
        logic [15:0] peer_port;
        t_result     expected_results[$];
        int unsigned errors;
        int unsigned segments;
        int unsigned requests;
        int unsigned headers;
        int unsigned deliveries;
        int unsigned checked;

        function new();
            regs.local_port     = RST_LOCAL_PORT;
            regs.initial_seq    = RST_INIT_SEQ;
            regs.max_rx_payload = RST_MAX_RX;
            regs.max_tx_packet  = RST_MAX_TX;
            phase      = PH_CLOSED;
            snd_seq    = '0;
            rcv_ack    = '0;
            peer_port  = '0;
            errors     = 0;
            segments   = 0;
            requests   = 0;
            headers    = 0;
            deliveries = 0;
            checked    = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [31:0] value);
            case (idx)
                REG_LOCAL_PORT: regs.local_port = value[15:0];
                REG_INIT_SEQ:   regs.initial_seq = value;
                REG_MAX_RX:     regs.max_rx_payload = value[15:0];
                REG_MAX_TX:     regs.max_tx_packet = value[15:0];
                default:        ;
            endcase
        endfunction

        // header fields always carry the state as it stands after the update
        function void put_header(inout t_result r, input logic [7:0] flags,
                                 input logic [15:0] len);
            r.tx_valid    = 1'b1;
            r.tx_flags    = flags;
            r.tx_seq      = snd_seq;
            r.tx_ack      = rcv_ack;
            r.tx_dst_port = peer_port;
            r.tx_length   = len;
        endfunction

        // advance the connection by one accepted word and queue its result
        function void predict_result(input t_item it);
            t_result    r;
            logic [5:0] hdr_len;
            logic [15:0] pay;
            logic [1:0] st;
            r  = '0;
            st = ST_OK;
            if (it.kind == KIND_SEGMENT) begin
                segments++;
                hdr_len = {it.data_offset, 2'b00};
                pay = (it.ip_payload_len >= {10'd0, hdr_len}) ?
                      it.ip_payload_len - {10'd0, hdr_len} : 16'd0;
                if (it.seg_dst_port != regs.local_port) begin
                    st = ST_PORT;
                end else if (it.seg_flags == FLAG_SYN) begin
                    // a syn only opens a closed connection, otherwise dropped quietly
                    if (phase == PH_CLOSED) begin
                        peer_port = it.seg_src_port;
                        snd_seq   = regs.initial_seq;
                        rcv_ack   = it.seg_seq + 32'd1;
                        phase     = PH_SYNRCVD;
                        put_header(r, FLAG_SYN | FLAG_ACK, HDR_BYTES);
                    end
                end else if (it.seg_flags == FLAG_ACK && phase == PH_SYNRCVD) begin
                    if (it.seg_ack == snd_seq + 32'd1)
                        phase = PH_ESTAB;
                end else if (phase != PH_ESTAB) begin
                    st = ST_NOCONN;
                end else if (pay != 16'd0 && pay < regs.max_rx_payload) begin
                    rcv_ack = it.seg_seq + {16'd0, pay};
                    snd_seq = it.seg_ack;
                    r.deliver_valid = 1'b1;
                    r.deliver_len   = pay;
                    deliveries++;
                    put_header(r, FLAG_ACK, HDR_BYTES);
                end else begin
                    // oversized or empty: only the ack bit moves our sequence
                    if ((it.seg_flags & FLAG_ACK) != 8'd0)
                        snd_seq = it.seg_ack;
                    if (pay != 16'd0)
                        st = ST_LONG;
                end
            end else begin
                requests++;
                if (phase != PH_ESTAB)
                    st = ST_NOCONN;
                else if ({8'd0, it.tx_payload_len} + HDR_BYTES >= regs.max_tx_packet)
                    st = ST_LONG;
                else
                    put_header(r, FLAG_PSH | FLAG_ACK, {8'd0, it.tx_payload_len} + HDR_BYTES);
            end
            if (r.tx_valid)
                headers++;
            case (phase)
                PH_SYNRCVD: r.conn_state = CS_SYNRCVD;
                PH_ESTAB:   r.conn_state = CS_ESTAB;
                default:    r.conn_state = CS_CLOSED;
            endcase
            r.status = st;
            expected_results.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                $error("result word arrived with no prediction pending");
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
            compare_field("tx_flags", 32'(want.tx_flags), 32'(got.tx_flags));
            compare_field("tx_seq", want.tx_seq, got.tx_seq);
            compare_field("tx_ack", want.tx_ack, got.tx_ack);
            compare_field("tx_dst_port", 32'(want.tx_dst_port), 32'(got.tx_dst_port));
            compare_field("tx_length", 32'(want.tx_length), 32'(got.tx_length));
            compare_field("deliver_valid", 32'(want.deliver_valid), 32'(got.deliver_valid));
            compare_field("deliver_len", 32'(want.deliver_len), 32'(got.deliver_len));
            compare_field("conn_state", 32'(want.conn_state), 32'(got.conn_state));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    // the limit sits well above the slowest legal run, leaving plenty of margin
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_PER_SETTING = 190;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    // tdata from bit 0: ip_payload_len(16) data_offset(4) seg_src_port(16)
    // seg_dst_port(16) seg_seq(32) seg_ack(32) seg_flags(8) tx_payload_len(8)
    logic [IN_DATA_W-1:0]    i_s_tdata;
    // tuser: kind(1)
    logic                    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    // tdata from bit 0: tx_flags(8) tx_seq(32) tx_ack(32) tx_dst_port(16)
    // tx_length(16) deliver_len(16) conn_state(2) status(2)
    logic [OUT_DATA_W-1:0]   o_m_tdata;
    // tuser from bit 0: tx_valid(1) deliver_valid(1)
    logic [OUT_USER_W-1:0]   o_m_tuser;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    conn_scoreboard sb = new();

    // when set, neither side inserts idle cycles
    bit          no_idle = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned reg_writes = 0;
    t_result     seen_word;

    tcp_server_handshake_tracker_top i_dut (.*);

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run as a failure
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timeout after %0d cycles, %0d results still pending",
               cycle_count, sb.expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result monitor: unpack the master-side word and check it
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_word.tx_valid      = o_m_tuser[0];
            seen_word.deliver_valid = o_m_tuser[1];
            seen_word.tx_flags      = o_m_tdata[7:0];
            seen_word.tx_seq        = o_m_tdata[39:8];
            seen_word.tx_ack        = o_m_tdata[71:40];
            seen_word.tx_dst_port   = o_m_tdata[87:72];
            seen_word.tx_length     = o_m_tdata[103:88];
            seen_word.deliver_len   = o_m_tdata[119:104];
            seen_word.conn_state    = o_m_tdata[121:120];
            seen_word.status        = o_m_tdata[123:122];
            sb.check_result(seen_word);
        end
    end

    // receiver: stall a random number of cycles before taking each result
    initial begin
        int unsigned stall;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    // fully random word, every field drawn over its whole range
    function automatic t_item noise_word();
        t_item it;
        it.kind           = 1'($urandom);
        it.ip_payload_len = 16'($urandom);
        it.data_offset    = 4'($urandom);
        it.seg_src_port   = 16'($urandom);
        it.seg_dst_port   = 16'($urandom);
        it.seg_seq        = $urandom;
        it.seg_ack        = $urandom;
        it.seg_flags      = 8'($urandom);
        it.tx_payload_len = 8'($urandom);
        return it;
    endfunction

    // segment with chosen header fields; tx_payload_len stays random
    function automatic t_item make_segment(input logic [15:0] dst, input logic [15:0] src,
                                           input logic [31:0] sseq, input logic [31:0] sack,
                                           input logic [7:0] flags, input logic [15:0] ip_len,
                                           input logic [3:0] doff);
        t_item it;
        it = noise_word();
        it.kind           = KIND_SEGMENT;
        it.seg_dst_port   = dst;
        it.seg_src_port   = src;
        it.seg_seq        = sseq;
        it.seg_ack        = sack;
        it.seg_flags      = flags;
        it.ip_payload_len = ip_len;
        it.data_offset    = doff;
        return it;
    endfunction

    // transmit request; the segment fields carry random junk
    function automatic t_item make_request(input logic [7:0] len);
        t_item it;
        it = noise_word();
        it.kind           = KIND_TRANSMIT;
        it.tx_payload_len = len;
        return it;
    endfunction

    // random traffic aimed at an established connection: mostly well-formed
    // data segments to our port, plus transmits, empty acks and noise
    function automatic t_item random_word();
        t_item       it;
        int unsigned pick;
        int unsigned hlen;
        int unsigned pay;
        int unsigned pay_cap;
        int unsigned ip;
        int          near_len;
        it = noise_word();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.kind         = KIND_SEGMENT;
            it.seg_dst_port = sb.regs.local_port;
            it.data_offset  = 4'($urandom_range(5, 15));
            hlen = 4 * 32'(it.data_offset);
            pay_cap = (sb.regs.max_rx_payload > 16'd1) ? 32'(sb.regs.max_rx_payload) - 1 : 1;
            if (pay_cap > 1460)
                pay_cap = 1460;
            // aim at both sides of the receive limit now and then
            case ($urandom_range(0, 7))
                0:       pay = 32'(sb.regs.max_rx_payload) - 1;
                1:       pay = 32'(sb.regs.max_rx_payload);
                2:       pay = $urandom_range(32'(sb.regs.max_rx_payload), 65535);
                default: pay = $urandom_range(1, pay_cap);
            endcase
            ip = hlen + pay;
            if (ip > 65535)
                ip = 65535;
            it.ip_payload_len = 16'(ip);
            case ($urandom_range(0, 6))
                0, 1, 2: it.seg_flags = FLAG_ACK;
                3:       it.seg_flags = FLAG_PSH | FLAG_ACK;
                4:       it.seg_flags = FLAG_PSH;
                5:       it.seg_flags = FLAG_SYN;
                default: ;
            endcase
        end else if (pick < 75) begin
            it.kind = KIND_TRANSMIT;
            // hit the transmit size limit exactly or one below
            near_len = int'(sb.regs.max_tx_packet) - 20 - int'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0 && near_len >= 0 && near_len <= 255)
                it.tx_payload_len = 8'(near_len);
        end else if (pick < 85) begin
            // header only, or ip length short of the header
            it.kind           = KIND_SEGMENT;
            it.seg_dst_port   = sb.regs.local_port;
            it.ip_payload_len = 16'($urandom_range(0, 4 * 32'(it.data_offset)));
            if ($urandom_range(0, 1) == 0)
                it.seg_flags = FLAG_ACK;
        end else if (pick < 93) begin
            it.kind         = KIND_SEGMENT;
            it.seg_dst_port = sb.regs.local_port ^ 16'($urandom_range(1, 65535));
        end
        return it;
    endfunction

    // present one word on the slave side and wait for it to be taken;
    // tvalid stays high afterwards so back-to-back words need no toggle
    task automatic push_word(input t_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tuser  = it.kind;
        i_s_tdata  = {4'd0, it.tx_payload_len, it.seg_flags, it.seg_ack, it.seg_seq,
                      it.seg_dst_port, it.seg_src_port, it.data_offset, it.ip_payload_len};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.predict_result(it);
        @(negedge i_clk);
    endtask

    // drain: stop sending and wait for every predicted result plus pipeline slack
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // apb write: setup cycle then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        reg_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] port, input logic [31:0] iseq,
                                 input logic [15:0] rx_max, input logic [15:0] tx_max);
        settle();
        write_reg(REG_LOCAL_PORT, {16'd0, port});
        write_reg(REG_INIT_SEQ, iseq);
        write_reg(REG_MAX_RX, {16'd0, rx_max});
        write_reg(REG_MAX_TX, {16'd0, tx_max});
    endtask

    // random words, with stretches of back-to-back traffic mixed in
    task automatic run_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            push_word(random_word());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        logic [15:0] lp;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: registers at reset values, connection starts closed
        lp = RST_LOCAL_PORT;
        // nothing works before the handshake
        push_word(make_request(8'd10));
        push_word(make_segment(lp, 16'd1234, $urandom, $urandom, FLAG_PSH | FLAG_ACK,
                               16'd60, 4'd5));
        // wrong port refused even for a syn
        push_word(make_segment(16'd0, 16'd80, $urandom, $urandom, FLAG_SYN, 16'd20, 4'd5));
        push_word(make_segment(~lp, 16'd80, $urandom, $urandom, FLAG_SYN, 16'd20, 4'd5));
        // syn opens the connection; peer sequence all ones wraps the ack to zero
        push_word(make_segment(lp, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, FLAG_SYN, 16'd20, 4'd5));
        // repeated syn ignored while not closed
        push_word(make_segment(lp, 16'h1111, $urandom, $urandom, FLAG_SYN, 16'd20, 4'd5));
        // ack with the wrong number leaves us in syn received
        push_word(make_segment(lp, 16'hFFFF, $urandom, RST_INIT_SEQ, FLAG_ACK,
                               16'd20, 4'd5));
        // data and transmit before established
        push_word(make_segment(lp, 16'hFFFF, $urandom, $urandom, FLAG_PSH | FLAG_ACK,
                               16'd30, 4'd5));
        push_word(make_request(8'd0));
        // matching ack completes the handshake
        push_word(make_segment(lp, 16'hFFFF, $urandom, RST_INIT_SEQ + 32'd1, FLAG_ACK,
                               16'd20, 4'd5));
        // transmit sizes around the packet limit
        push_word(make_request(8'd0));
        push_word(make_request(8'd179));
        push_word(make_request(8'd180));
        push_word(make_request(8'd255));
        // smallest and largest accepted payloads, sequence wrap on the ack
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_ACK,
                               16'd21, 4'd5));
        push_word(make_segment(lp, 16'($urandom), 32'hFFFF_FF00, $urandom,
                               FLAG_PSH | FLAG_ACK, 16'd1059, 4'd15));
        // payload at the limit with the ack bit, then over the limit without it
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_ACK,
                               16'd1000, 4'd0));
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_PSH,
                               16'd2020, 4'd5));
        // empty segments: pure ack, no flags, ip length shorter than the header
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_ACK,
                               16'd20, 4'd5));
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, 8'd0,
                               16'd20, 4'd5));
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_ACK,
                               16'd4, 4'd15));
        // field extremes: all flags, longest lengths
        push_word(make_segment(lp, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                               16'hFFFF, 4'd15));
        push_word(make_segment(lp, 16'd0, 32'd0, 32'd0, FLAG_ACK, 16'hFFFF, 4'd0));
        // syn once established is dropped; a bare ack with data is delivered
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_SYN,
                               16'd20, 4'd5));
        push_word(make_segment(lp, 16'($urandom), $urandom, $urandom, FLAG_ACK,
                               16'd70, 4'd5));

        // random phases across register settings, extremes included
        apply_setting(RST_LOCAL_PORT, 32'hFFFF_FFFF, RST_MAX_RX, RST_MAX_TX);
        run_random(RANDOM_PER_SETTING);
        apply_setting(16'd0, 32'd0, 16'd1, 16'd21);
        run_random(RANDOM_PER_SETTING);
        apply_setting(16'hFFFF, $urandom, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_SETTING);
        apply_setting(16'($urandom), $urandom, 16'($urandom_range(2, 4000)),
                      16'($urandom_range(21, 300)));
        run_random(RANDOM_PER_SETTING);
        apply_setting(RST_LOCAL_PORT, $urandom, RST_MAX_RX, RST_MAX_TX);
        run_random(RANDOM_PER_SETTING);

        // drain and give any stray result a chance to show up
        settle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d segments and %0d transmit requests with %0d register writes",
                 sb.segments, sb.requests, reg_writes);
        $display("checked %0d results: %0d headers sent, %0d payloads delivered, %0d cycles",
                 sb.checked, sb.headers, sb.deliveries, cycle_count);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
